// ===== sv/n2a_pkg.sv =====
// n2a_pkg: shared types, constants and helpers for the number to ascii formatter
// depends on nothing; imported by n2a_digit_cell, number_to_ascii_formatter and n2a_checker

package n2a_pkg;

    // field widths of the item and result channels
    localparam int VALUE_BITS      = 32;
    localparam int COUNT_BITS      = 4;
    localparam int CHAR_BITS       = 7;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int HEX_MAX_DIGITS  = 8;

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0] ASCII_A    = 7'h41;

    // format selector codes
    localparam logic KIND_HEX = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    // per-cycle operation of every digit cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_DABBLE,
        CELL_SHIFT
    } t_cell_op;

    // control handed from the sequencer to the row of cells
    typedef struct packed {
        t_cell_op op;
        logic     shift_bit;
    } t_cell_ctrl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_EMIT
    } t_state;

    // digit 0..15 to upper-case ascii
    function automatic logic [CHAR_BITS-1:0] hex_ascii(input logic [3:0] nib);
        logic [CHAR_BITS-1:0] ext;
        ext = {3'b000, nib};
        if (nib < 4'd10) begin
            return ASCII_ZERO + ext;
        end
        return ASCII_A + ext - 7'd10;
    endfunction

endpackage

// ===== sv/n2a_digit_cell.sv =====
// n2a_digit_cell: one 4-bit digit cell of the conversion chain
// depends on n2a_pkg; instantiated in a row by number_to_ascii_formatter

module n2a_digit_cell import n2a_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic [3:0] i_load_nib,
    input  logic       i_carry_in,
    input  logic [3:0] i_lower_digit,
    output logic [3:0] o_digit,
    output logic       o_carry
);

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] adj;

    // add-3 correction before the doubling step
    assign adj     = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
    assign o_carry = adj[3];
    assign o_digit = r_digit;

    // next digit value
    always_comb begin
        unique case (i_ctrl.op)
            CELL_HOLD:   n_digit = r_digit;
            CELL_LOAD:   n_digit = i_load_nib;
            CELL_DABBLE: n_digit = {adj[2:0], i_carry_in};
            CELL_SHIFT:  n_digit = i_lower_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== sv/number_to_ascii_formatter.sv =====
// number_to_ascii_formatter: hex / decimal ascii formatter, sequencer plus digit chain
// sequence: hex loads, shifts out unrequested leading digits, then emits; decimal loads, runs
// double dabble over the value bits, drops leading zeros, then emits (10 cells at 32 bits)
// throughput: one item at a time; a new item is taken only once the last character is taken
// reset: i_rst_n synchronous, active low, returns the sequencer to idle; digit cells are not reset

module number_to_ascii_formatter import n2a_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_kind,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [COUNT_BITS-1:0] i_digit_count,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CHAR_BITS-1:0]  o_ascii_char,
    output logic                  o_last_char
);

    // bits actually used from the value port
    localparam int W_EFF   = (VALUE_WIDTH < VALUE_BITS) ? VALUE_WIDTH : VALUE_BITS;
    localparam int W_PAD   = 4 * ((W_EFF + 3) / 4);
    localparam int N_DEC   = (W_EFF * 31) / 100 + 1;
    localparam int N_CELL  = (N_DEC > HEX_MAX_DIGITS) ? N_DEC : HEX_MAX_DIGITS;
    localparam int CNT_W   = $clog2(N_CELL + 1);
    localparam int BIT_W   = $clog2(W_EFF + 1);
    localparam int N_NIB   = W_PAD / 4;

    t_state              r_state;
    t_state              n_state;
    logic                r_kind;
    logic [COUNT_BITS-1:0] r_n;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [BIT_W-1:0]    r_bits;
    logic [W_EFF-1:0]    r_bin;
    t_cell_ctrl          ctrl;
    logic                accept_in;
    logic                accept_out;
    logic                skip;
    logic [COUNT_BITS-1:0] clamped;
    logic [W_EFF-1:0]    in_val;
    logic [W_PAD-1:0]    pad_val;
    logic [3:0]          top_digit;

    logic [3:0] w_digit [N_CELL];
    logic       w_carry [N_CELL+1];
    logic [3:0] w_load  [N_CELL];

    assign in_val    = i_value[W_EFF-1:0];
    assign pad_val   = W_PAD'(in_val);
    assign clamped   = (i_digit_count > COUNT_BITS'(HEX_MAX_DIGITS))
                       ? COUNT_BITS'(HEX_MAX_DIGITS) : i_digit_count;
    assign accept_in  = i_in_valid && !o_in_stall;
    assign accept_out = o_out_valid && !i_out_stall;
    assign top_digit  = w_digit[N_CELL-1];

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = (r_state == ST_EMIT);
    assign o_ascii_char = hex_ascii(top_digit);
    assign o_last_char  = (r_cnt == CNT_W'(1));

    // leading-digit skip: decimal drops zeros, hex aligns the requested digits to the top
    always_comb begin
        if (r_kind == KIND_DEC) begin
            skip = (top_digit == 4'd0) && (r_cnt > CNT_W'(1));
        end else begin
            skip = ({{(CNT_W){1'b0}}, r_n} > {{(COUNT_BITS){1'b0}}, r_cnt}) ? 1'b0
                 : ({{(COUNT_BITS){1'b0}}, r_cnt} > {{(CNT_W){1'b0}}, r_n});
        end
    end

    // load pattern: hex nibbles in hex mode, zeros in decimal mode
    for (genvar g = 0; g < N_CELL; g++) begin : g_load
        if (g < N_NIB) begin : g_nib
            assign w_load[g] = (i_kind == KIND_HEX) ? pad_val[4*g +: 4] : 4'd0;
        end else begin : g_zero
            assign w_load[g] = 4'd0;
        end
    end

    // row of digit cells; the binary msb enters at the low end
    assign w_carry[0] = ctrl.shift_bit;
    for (genvar g = 0; g < N_CELL; g++) begin : g_cell
        n2a_digit_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_load_nib    (w_load[g]),
            .i_carry_in    (w_carry[g]),
            .i_lower_digit ((g == 0) ? 4'd0 : w_digit[(g == 0) ? 0 : g-1]),
            .o_digit       (w_digit[g]),
            .o_carry       (w_carry[g+1])
        );
    end

    // next state and cell control
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        ctrl.op        = CELL_HOLD;
        ctrl.shift_bit = r_bin[W_EFF-1];
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    ctrl.op = CELL_LOAD;
                    n_cnt   = CNT_W'(N_CELL);
                    if (i_kind == KIND_DEC) begin
                        n_state = ST_CONV;
                    end else if (clamped != '0) begin
                        n_state = ST_ALIGN;
                    end
                end
            end
            ST_CONV: begin
                ctrl.op = CELL_DABBLE;
                if (r_bits == BIT_W'(1)) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                if (skip) begin
                    ctrl.op = CELL_SHIFT;
                    n_cnt   = r_cnt - CNT_W'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (accept_out) begin
                    ctrl.op = CELL_SHIFT;
                    n_cnt   = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item registers and binary shifter
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (accept_in) begin
            r_kind <= i_kind;
            r_n    <= clamped;
            r_bin  <= in_val;
            r_bits <= BIT_W'(W_EFF);
        end else if (r_state == ST_CONV) begin
            r_bin  <= {r_bin[W_EFF-2:0], 1'b0};
            r_bits <= r_bits - BIT_W'(1);
        end
    end

endmodule

// ===== sv/n2a_checker.sv =====
// n2a_checker: port-level assertions for number_to_ascii_formatter
// depends on n2a_pkg; bound to the top level by the bind statement below

module n2a_checker import n2a_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [CHAR_BITS-1:0] o_ascii_char,
    input logic                 o_last_char
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_ascii_char) && $stable(o_last_char))
        else $error("stalled result changed");

    // only digit characters come out
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_ascii_char >= ASCII_ZERO && o_ascii_char <= 7'h39) ||
            (o_ascii_char >= ASCII_A && o_ascii_char <= 7'h46))
        else $error("result is not a digit character");

    // no new item while characters are pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("item taken while results pending");

    // run ends after the last character
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last_char |=> !o_out_valid)
        else $error("result after the last character");

    // no result appears in the cycle after an item is accepted
    a_no_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !o_out_valid)
        else $error("result in the cycle after accept");

endmodule

bind number_to_ascii_formatter n2a_checker u_n2a_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_ascii_char (o_ascii_char),
    .o_last_char  (o_last_char)
);
